FILE: hdl/sqv_pkg.sv
`default_nettype none

package sqv_pkg;

    typedef enum logic [1:0] {
        MODE_TICK    = 2'd0,
        MODE_QUARTER = 2'd1,
        MODE_HALF    = 2'd2,
        MODE_LOAD    = 2'd3
    } mode_t;

    localparam logic [2:0] REG_DUTY_MODE       = 3'd0;
    localparam logic [2:0] REG_ENVELOPE_PERIOD = 3'd1;
    localparam logic [2:0] REG_FIXED_VOLUME    = 3'd2;
    localparam logic [2:0] REG_ENVELOPE_MODE   = 3'd3;
    localparam logic [2:0] REG_SWEEP_CONTROL   = 3'd4;
    localparam logic [2:0] REG_LENGTH_ENABLE   = 3'd5;
    localparam logic [2:0] REG_VOICE_ENABLE    = 3'd6;
    localparam logic [2:0] REG_ONES_NEGATE     = 3'd7;

    localparam logic [3:0]  ENV_TOP    = 4'd15;
    localparam logic [15:0] PERIOD_MIN = 16'd8;
    localparam logic [15:0] PERIOD_MAX = 16'h07FF;

    localparam logic [3:0][7:0] DUTY_PATTERNS = {8'hF9, 8'h1E, 8'h06, 8'h02};

    typedef struct packed {
        logic [1:0] duty_mode;
        logic [3:0] envelope_period;
        logic [3:0] fixed_volume;
        logic [1:0] envelope_mode;
        logic [7:0] sweep_control;
        logic       length_count_enable;
        logic       voice_enable;
        logic       ones_complement_negate;
    } cfg_t;

    typedef struct packed {
        mode_t       mode;
        logic [10:0] period_load;
        logic [7:0]  length_load;
        logic        restart_envelope;
        logic        reload_sweep;
    } item_t;

    typedef struct packed {
        logic [3:0]  level;
        logic [15:0] current_period;
        logic [7:0]  length_left;
    } result_t;

    function automatic logic duty_bit(input logic [1:0] mode, input logic [2:0] phase);
        logic [7:0] pattern;
        pattern = DUTY_PATTERNS[mode];
        return pattern[phase];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/sqv_core.sv
`default_nettype none

module sqv_core (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             step,
    input  wire sqv_pkg::cfg_t    cfg,
    input  wire sqv_pkg::item_t   item,
    output sqv_pkg::result_t      result
);

    logic [15:0] period_reg, period_next;
    logic [15:0] timer_count_reg, timer_count_next;
    logic [2:0]  duty_phase_reg, duty_phase_next;
    logic        env_start_reg, env_start_next;
    logic [3:0]  env_divider_reg, env_divider_next;
    logic [3:0]  env_level_reg, env_level_next;
    logic        sweep_reload_reg, sweep_reload_next;
    logic [2:0]  sweep_divider_reg, sweep_divider_next;
    logic [7:0]  length_reg, length_next;

    // envelope clocked
    logic [3:0]  env_div_clk, env_lvl_clk;
    // sweep clocked
    logic [15:0] sweep_delta, sweep_period;
    logic [15:0] period_swept;
    logic [2:0]  sweep_div_clk;
    logic        sweep_on;
    logic [2:0]  sweep_reload_val;
    logic        level_on;

    always_comb begin
        env_div_clk = env_divider_reg;
        env_lvl_clk = env_level_reg;
        if (env_start_reg) begin
            env_lvl_clk = sqv_pkg::ENV_TOP;
            env_div_clk = cfg.envelope_period;
        end else if (env_divider_reg != 4'd0) begin
            env_div_clk = env_divider_reg - 4'd1;
        end else begin
            if (env_level_reg != 4'd0) begin
                env_lvl_clk = env_level_reg - 4'd1;
            end else if (cfg.envelope_mode[1]) begin
                env_lvl_clk = sqv_pkg::ENV_TOP;
            end
            env_div_clk = cfg.envelope_period;
        end
    end

    assign sweep_on         = cfg.sweep_control[7];
    assign sweep_reload_val = cfg.sweep_control[6:4];
    assign sweep_delta      = period_reg >> cfg.sweep_control[2:0];

    // ones' complement negate: p - d - 1 = p + ~d
    always_comb begin
        if (cfg.sweep_control[3]) begin
            if (cfg.ones_complement_negate) begin
                sweep_period = period_reg + ~sweep_delta;
            end else begin
                sweep_period = period_reg - sweep_delta;
            end
        end else begin
            sweep_period = period_reg + sweep_delta;
        end
    end

    always_comb begin
        period_swept  = period_reg;
        sweep_div_clk = sweep_divider_reg;
        if (sweep_reload_reg) begin
            if (sweep_on && sweep_divider_reg == 3'd0) begin
                period_swept = sweep_period;
            end
            sweep_div_clk = sweep_reload_val;
        end else if (sweep_divider_reg != 3'd0) begin
            sweep_div_clk = sweep_divider_reg - 3'd1;
        end else begin
            if (sweep_on) begin
                period_swept = sweep_period;
            end
            sweep_div_clk = sweep_reload_val;
        end
    end

    always_comb begin
        period_next        = period_reg;
        timer_count_next   = timer_count_reg;
        duty_phase_next    = duty_phase_reg;
        env_start_next     = env_start_reg;
        env_divider_next   = env_divider_reg;
        env_level_next     = env_level_reg;
        sweep_reload_next  = sweep_reload_reg;
        sweep_divider_next = sweep_divider_reg;
        length_next        = length_reg;
        unique case (item.mode)
            sqv_pkg::MODE_TICK: begin
                if (timer_count_reg == 16'd0) begin
                    timer_count_next = period_reg;
                    duty_phase_next  = duty_phase_reg + 3'd1;
                end else begin
                    timer_count_next = timer_count_reg - 16'd1;
                end
            end
            sqv_pkg::MODE_QUARTER: begin
                env_start_next   = 1'b0;
                env_divider_next = env_div_clk;
                env_level_next   = env_lvl_clk;
            end
            sqv_pkg::MODE_HALF: begin
                env_start_next     = 1'b0;
                env_divider_next   = env_div_clk;
                env_level_next     = env_lvl_clk;
                period_next        = period_swept;
                sweep_divider_next = sweep_div_clk;
                sweep_reload_next  = 1'b0;
                if (cfg.length_count_enable && length_reg != 8'd0) begin
                    length_next = length_reg - 8'd1;
                end
            end
            sqv_pkg::MODE_LOAD: begin
                period_next = {5'd0, item.period_load};
                length_next = item.length_load;
                if (item.restart_envelope) begin
                    env_start_next = 1'b1;
                end
                if (item.reload_sweep) begin
                    sweep_reload_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign level_on = cfg.voice_enable && (length_next != 8'd0)
                   && sqv_pkg::duty_bit(cfg.duty_mode, duty_phase_next)
                   && (period_next >= sqv_pkg::PERIOD_MIN)
                   && (period_next <= sqv_pkg::PERIOD_MAX);

    always_comb begin
        result.current_period = period_next;
        result.length_left    = length_next;
        if (!level_on) begin
            result.level = 4'd0;
        end else if (cfg.envelope_mode[0]) begin
            result.level = env_level_next;
        end else begin
            result.level = cfg.fixed_volume;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg        <= '0;
            timer_count_reg   <= '0;
            duty_phase_reg    <= '0;
            env_start_reg     <= 1'b0;
            env_divider_reg   <= '0;
            env_level_reg     <= '0;
            sweep_reload_reg  <= 1'b0;
            sweep_divider_reg <= '0;
            length_reg        <= '0;
        end else if (step) begin
            period_reg        <= period_next;
            timer_count_reg   <= timer_count_next;
            duty_phase_reg    <= duty_phase_next;
            env_start_reg     <= env_start_next;
            env_divider_reg   <= env_divider_next;
            env_level_reg     <= env_level_next;
            sweep_reload_reg  <= sweep_reload_next;
            sweep_divider_reg <= sweep_divider_next;
            length_reg        <= length_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/square_wave_voice_channel.sv
// Square-wave voice: one event per input beat, one result beat per event.
// Input channel s_*: s_tuser carries the event kind (tick, quarter frame,
// half frame, load); s_tdata carries the load fields.
// Result channel m_*: level, period and length count after the event.
// Configuration channel cfg_*: cfg_index selects a register, cfg_data is
// written when cfg_valid is high; cfg_ready is always high. Write only
// while no event is in flight.
// An accepted beat is captured in the input register, passes through the
// core logic and is loaded into the result register, which drives
// m_tvalid; that load waits while a held result has not been taken.
// Throughput: one beat per cycle while m_tready is high; the state update
// is a single pass of compare/add logic between input and result register.
// When m_tready is low the result register holds, the input register fills,
// and s_tready drops until the result is taken.
// Reset (aresetn low, synchronous) empties both registers, clears the
// voice state and sets all registers to zero, except the ones' complement
// negate flag, which comes up set.
`default_nettype none

module square_wave_voice_channel (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [10:0] period_load, [18:11] length_load, [19] restart_envelope,
    // [20] reload_sweep, [23:21] zero
    input  wire logic [23:0] s_tdata,
    // [1:0] mode
    input  wire logic [1:0]  s_tuser,

    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [3:0] level, [19:4] current_period, [27:20] length_left, [31:28] zero
    output logic [31:0]      m_tdata,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    sqv_pkg::cfg_t    cfg_reg;
    sqv_pkg::item_t   item_reg;
    sqv_pkg::result_t result_next;
    sqv_pkg::result_t result_reg;
    logic             in_valid_reg;
    logic             out_valid_reg;
    logic             advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {4'd0, result_reg.length_left, result_reg.current_period,
                        result_reg.level};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{duty_mode: 2'd0, envelope_period: 4'd0, fixed_volume: 4'd0,
                         envelope_mode: 2'd0, sweep_control: 8'd0,
                         length_count_enable: 1'b0, voice_enable: 1'b0,
                         ones_complement_negate: 1'b1};
        end else if (cfg_valid) begin
            unique case (cfg_index)
                sqv_pkg::REG_DUTY_MODE:       cfg_reg.duty_mode <= cfg_data[1:0];
                sqv_pkg::REG_ENVELOPE_PERIOD: cfg_reg.envelope_period <= cfg_data[3:0];
                sqv_pkg::REG_FIXED_VOLUME:    cfg_reg.fixed_volume <= cfg_data[3:0];
                sqv_pkg::REG_ENVELOPE_MODE:   cfg_reg.envelope_mode <= cfg_data[1:0];
                sqv_pkg::REG_SWEEP_CONTROL:   cfg_reg.sweep_control <= cfg_data;
                sqv_pkg::REG_LENGTH_ENABLE:   cfg_reg.length_count_enable <= cfg_data[0];
                sqv_pkg::REG_VOICE_ENABLE:    cfg_reg.voice_enable <= cfg_data[0];
                sqv_pkg::REG_ONES_NEGATE:     cfg_reg.ones_complement_negate <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.mode             <= sqv_pkg::mode_t'(s_tuser);
            item_reg.period_load      <= s_tdata[10:0];
            item_reg.length_load      <= s_tdata[18:11];
            item_reg.restart_envelope <= s_tdata[19];
            item_reg.reload_sweep     <= s_tdata[20];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    sqv_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .cfg     (cfg_reg),
        .item    (item_reg),
        .result  (result_next)
    );

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
module tb_top;

    class voice_scoreboard;
        sqv_pkg::cfg_t    regs;
        logic [15:0]      period_q;
        logic [15:0]      timer_q;
        logic [2:0]       phase_q;
        logic             env_restart_q;
        logic [3:0]       env_div_q;
        logic [3:0]       env_vol_q;
        logic             sweep_reload_q;
        logic [2:0]       sweep_div_q;
        logic [7:0]       length_q;
        sqv_pkg::result_t pending[$];
        int               errors;

        function new();
            regs = '0;
            regs.ones_complement_negate = 1'b1;
            period_q = '0;
            timer_q = '0;
            phase_q = '0;
            env_restart_q = 1'b0;
            env_div_q = '0;
            env_vol_q = '0;
            sweep_reload_q = 1'b0;
            sweep_div_q = '0;
            length_q = '0;
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [7:0] val);
            case (idx)
                sqv_pkg::REG_DUTY_MODE:       regs.duty_mode = val[1:0];
                sqv_pkg::REG_ENVELOPE_PERIOD: regs.envelope_period = val[3:0];
                sqv_pkg::REG_FIXED_VOLUME:    regs.fixed_volume = val[3:0];
                sqv_pkg::REG_ENVELOPE_MODE:   regs.envelope_mode = val[1:0];
                sqv_pkg::REG_SWEEP_CONTROL:   regs.sweep_control = val;
                sqv_pkg::REG_LENGTH_ENABLE:   regs.length_count_enable = val[0];
                sqv_pkg::REG_VOICE_ENABLE:    regs.voice_enable = val[0];
                sqv_pkg::REG_ONES_NEGATE:     regs.ones_complement_negate = val[0];
            endcase
        endfunction

        function void clock_envelope();
            if (env_restart_q) begin
                env_vol_q = 4'd15;
                env_div_q = regs.envelope_period;
                env_restart_q = 1'b0;
            end else if (env_div_q != 4'd0) begin
                env_div_q = env_div_q - 4'd1;
            end else begin
                if (env_vol_q != 4'd0)
                    env_vol_q = env_vol_q - 4'd1;
                else if (regs.envelope_mode[1])
                    env_vol_q = 4'd15;
                env_div_q = regs.envelope_period;
            end
        endfunction

        function void shift_period();
            logic [15:0] delta;
            delta = period_q >> regs.sweep_control[2:0];
            if (regs.sweep_control[3]) begin
                period_q = period_q - delta;
                if (regs.ones_complement_negate)
                    period_q = period_q - 16'd1;
            end else begin
                period_q = period_q + delta;
            end
        endfunction

        function void clock_sweep();
            if (sweep_reload_q) begin
                if (regs.sweep_control[7] && sweep_div_q == 3'd0)
                    shift_period();
                sweep_div_q = regs.sweep_control[6:4];
                sweep_reload_q = 1'b0;
            end else if (sweep_div_q != 3'd0) begin
                sweep_div_q = sweep_div_q - 3'd1;
            end else begin
                if (regs.sweep_control[7])
                    shift_period();
                sweep_div_q = regs.sweep_control[6:4];
            end
        endfunction

        function logic [3:0] level_now();
            logic [7:0] wave;
            case (regs.duty_mode)
                2'd0:    wave = 8'h02;
                2'd1:    wave = 8'h06;
                2'd2:    wave = 8'h1E;
                default: wave = 8'hF9;
            endcase
            if (!regs.voice_enable || length_q == 8'd0 || !wave[phase_q] ||
                period_q < 16'd8 || period_q > 16'h07FF)
                return 4'd0;
            return regs.envelope_mode[0] ? env_vol_q : regs.fixed_volume;
        endfunction

        function void note_event(sqv_pkg::item_t ev);
            sqv_pkg::result_t r;
            case (ev.mode)
                sqv_pkg::MODE_TICK: begin
                    if (timer_q == 16'd0) begin
                        timer_q = period_q;
                        phase_q = phase_q + 3'd1;
                    end else begin
                        timer_q = timer_q - 16'd1;
                    end
                end
                sqv_pkg::MODE_QUARTER: clock_envelope();
                sqv_pkg::MODE_HALF: begin
                    clock_envelope();
                    clock_sweep();
                    if (regs.length_count_enable && length_q != 8'd0)
                        length_q = length_q - 8'd1;
                end
                default: begin
                    period_q = {5'd0, ev.period_load};
                    length_q = ev.length_load;
                    if (ev.restart_envelope)
                        env_restart_q = 1'b1;
                    if (ev.reload_sweep)
                        sweep_reload_q = 1'b1;
                end
            endcase
            r.level = level_now();
            r.current_period = period_q;
            r.length_left = length_q;
            pending.push_back(r);
        endfunction

        function void check_output(logic [31:0] beat);
            sqv_pkg::result_t want;
            sqv_pkg::result_t got;
            got.level = beat[3:0];
            got.current_period = beat[19:4];
            got.length_left = beat[27:20];
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected beat: level %0d period %h length %0d",
                             got.level, got.current_period, got.length_left);
                return;
            end
            want = pending.pop_front();
            if (got.level !== want.level || got.current_period !== want.current_period ||
                got.length_left !== want.length_left) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp level %0d period %h length %0d, got %0d %h %0d",
                             want.level, want.current_period, want.length_left,
                             got.level, got.current_period, got.length_left);
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;

    voice_scoreboard board = new();
    logic [1:0]      rx_style = 2'd0;
    int              rx_tick = 0;
    bit              tx_gappy = 1'b0;
    int              burst_left = 0;

    square_wave_voice_channel dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial begin
        #3000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge aclk) begin
        rx_tick <= rx_tick + 1;
        if (aresetn && m_tvalid && m_tready)
            board.check_output(m_tdata);
        case (rx_style)
            2'd0:    m_tready <= 1'b1;
            2'd1:    m_tready <= ($urandom_range(9) < 7);
            2'd2:    m_tready <= (rx_tick % 7) < 4;
            default: m_tready <= (rx_tick % 29) > 11;
        endcase
    end

    function automatic sqv_pkg::item_t make_event(sqv_pkg::mode_t m, logic [10:0] p,
                                                  logic [7:0] l, logic r, logic s);
        sqv_pkg::item_t ev;
        ev.mode = m;
        ev.period_load = p;
        ev.length_load = l;
        ev.restart_envelope = r;
        ev.reload_sweep = s;
        return ev;
    endfunction

    function automatic sqv_pkg::item_t raw_event(sqv_pkg::mode_t m);
        return make_event(m, 11'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
    endfunction

    function automatic sqv_pkg::item_t tone_load();
        return make_event(sqv_pkg::MODE_LOAD, 11'($urandom_range(0, 40)),
                          ($urandom_range(3) == 0) ? 8'($urandom_range(1, 4))
                                                   : 8'($urandom_range(1, 255)),
                          1'($urandom), 1'($urandom));
    endfunction

    // ticks only while the period is short, so the timer keeps stepping the duty phase
    function automatic sqv_pkg::item_t tone_event();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60 && board.period_q <= 16'd64)
            return raw_event(sqv_pkg::MODE_TICK);
        if (pick < 60 || pick >= 90)
            return tone_load();
        return raw_event(pick < 75 ? sqv_pkg::MODE_QUARTER : sqv_pkg::MODE_HALF);
    endfunction

    function automatic sqv_pkg::item_t noise_event();
        int pick;
        pick = $urandom_range(2);
        if (pick == 0)
            return raw_event(sqv_pkg::MODE_QUARTER);
        if (pick == 1)
            return raw_event(sqv_pkg::MODE_HALF);
        return raw_event(sqv_pkg::MODE_LOAD);
    endfunction

    function automatic logic [7:0][7:0] random_setting();
        logic [7:0][7:0] s;
        for (int i = 0; i < 8; i++)
            s[i] = 8'($urandom);
        if (s[sqv_pkg::REG_SWEEP_CONTROL][3] && s[sqv_pkg::REG_SWEEP_CONTROL][2:0] == 3'd0)
            s[sqv_pkg::REG_SWEEP_CONTROL][0] = 1'b1;
        if ($urandom_range(4) != 0)
            s[sqv_pkg::REG_VOICE_ENABLE][0] = 1'b1;
        return s;
    endfunction

    task automatic send_event(input sqv_pkg::item_t ev);
        s_tvalid <= 1'b1;
        s_tuser  <= ev.mode;
        s_tdata  <= {3'd0, ev.reload_sweep, ev.restart_envelope, ev.length_load,
                     ev.period_load};
        do @(posedge aclk); while (!s_tready);
        board.note_event(ev);
        if (tx_gappy) begin
            if (burst_left == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
                burst_left = $urandom_range(1, 16);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic write_regs(input logic [7:0][7:0] vals, input logic [7:0] mask);
        for (int i = 0; i < 8; i++) begin
            if (mask[i]) begin
                cfg_valid <= 1'b1;
                cfg_index <= i[2:0];
                cfg_data  <= vals[i];
                do @(posedge aclk); while (!cfg_ready);
                board.set_reg(i[2:0], vals[i]);
            end
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge aclk);
    endtask

    // tone runs open with a load; noise runs are loads and frame beats with raw values
    task automatic run_phase(input int count);
        int  sent;
        int  run_len;
        bit  noisy;
        sent = 0;
        while (sent < count) begin
            noisy = ($urandom_range(4) == 0);
            run_len = $urandom_range(4, 40);
            for (int i = 0; i < run_len && sent < count; i++) begin
                if (noisy)
                    send_event(noise_event());
                else if (i == 0)
                    send_event(tone_load());
                else
                    send_event(tone_event());
                sent++;
            end
        end
    endtask

    initial begin
        logic [7:0][7:0] setting;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        setting[sqv_pkg::REG_DUTY_MODE]       = 8'd3;
        setting[sqv_pkg::REG_ENVELOPE_PERIOD] = 8'd1;
        setting[sqv_pkg::REG_FIXED_VOLUME]    = 8'd9;
        setting[sqv_pkg::REG_ENVELOPE_MODE]   = 8'd3;
        setting[sqv_pkg::REG_SWEEP_CONTROL]   = 8'h88;
        setting[sqv_pkg::REG_LENGTH_ENABLE]   = 8'd1;
        setting[sqv_pkg::REG_VOICE_ENABLE]    = 8'd1;
        setting[sqv_pkg::REG_ONES_NEGATE]     = 8'd1;
        write_regs(setting, 8'hFF);

        send_event(make_event(sqv_pkg::MODE_LOAD, 11'd8, 8'd3, 1'b1, 1'b1));
        send_event(make_event(sqv_pkg::MODE_TICK, 11'd0, 8'd0, 1'b0, 1'b0));
        send_event(make_event(sqv_pkg::MODE_QUARTER, 11'h7FF, 8'hFF, 1'b1, 1'b1));
        send_event(make_event(sqv_pkg::MODE_QUARTER, 11'd0, 8'd0, 1'b0, 1'b0));
        send_event(make_event(sqv_pkg::MODE_QUARTER, 11'd0, 8'd0, 1'b0, 1'b0));
        // negate with shift 0 and the extra one: wraps to all ones
        send_event(make_event(sqv_pkg::MODE_HALF, 11'd0, 8'd0, 1'b0, 1'b0));
        send_event(make_event(sqv_pkg::MODE_LOAD, 11'd7, 8'd1, 1'b0, 1'b0));
        send_event(make_event(sqv_pkg::MODE_HALF, 11'h7FF, 8'hFF, 1'b1, 1'b1));
        send_event(make_event(sqv_pkg::MODE_HALF, 11'd0, 8'd0, 1'b0, 1'b0));
        send_event(make_event(sqv_pkg::MODE_LOAD, 11'h7FF, 8'hFF, 1'b0, 1'b1));
        send_event(make_event(sqv_pkg::MODE_LOAD, 11'd0, 8'd0, 1'b1, 1'b0));
        send_event(make_event(sqv_pkg::MODE_QUARTER, 11'd0, 8'd0, 1'b0, 1'b0));
        drain();

        setting[sqv_pkg::REG_DUTY_MODE]     = 8'd0;
        setting[sqv_pkg::REG_ENVELOPE_MODE] = 8'd1;
        setting[sqv_pkg::REG_SWEEP_CONTROL] = 8'h80;
        setting[sqv_pkg::REG_ONES_NEGATE]   = 8'd0;
        write_regs(setting, 8'hFF);

        // doubling from the top of the load range until the period wraps
        send_event(make_event(sqv_pkg::MODE_LOAD, 11'h7FF, 8'hFF, 1'b1, 1'b1));
        repeat (6)
            send_event(make_event(sqv_pkg::MODE_HALF, 11'd0, 8'd0, 1'b0, 1'b0));
        send_event(make_event(sqv_pkg::MODE_LOAD, 11'h400, 8'd1, 1'b0, 1'b0));
        send_event(make_event(sqv_pkg::MODE_HALF, 11'd0, 8'd0, 1'b0, 1'b0));

        for (int k = 0; k < 12; k++) begin
            drain();
            if (k == 0)
                setting = '0;
            else if (k == 1)
                setting = '1;
            else
                setting = random_setting();
            write_regs(setting, (k < 2) ? 8'hFF : 8'($urandom_range(1, 255)));
            tx_gappy = (k % 3 != 0);
            burst_left = $urandom_range(1, 16);
            rx_style <= 2'(k % 4);
            run_phase(155);
        end

        drain();
        repeat (8) @(posedge aclk);
        if (board.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
